// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Item types and header constants shared by the deframer and its channels.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Largest length that the seven-bit field carries directly
	localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
	// Seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	// Byte counts of the extended length fields and of the mask key
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [3:0]  opcode;
		logic        fin_flag;
		logic        was_masked;
		logic [63:0] frame_length;
		logic        empty_frame;
		logic        last_of_frame;
	} result_item_t;

endpackage

// ===== sv/wsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer byte channel
// Valid/ready channel that carries one raw stream byte per item.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
	logic                valid;
	logic                ready;
	wsd_pkg::byte_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/wsd_result_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer result channel
// Valid/ready channel that carries one unmasked payload item per transfer.
// ----------------------------------------------------------------------------
interface wsd_result_if;
	logic                  valid;
	logic                  ready;
	wsd_pkg::result_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// A byte is taken into the input register, then moves on to the result register,
// which drives the result channel; the move waits while the result register
// holds an item that the result side has not taken.
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// Header bytes give no item, except the last one of a zero-length frame.
// Reset (arst_n low) returns the parser to the first header byte, empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	wsd_byte_if.sink             data,
	wsd_result_if.source         result
);

	// Parser phase: where in the frame the next byte belongs
	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Frame state
	phase_t      phase_q,     phase_n;
	logic [3:0]  opcode_q,    opcode_n;
	logic        fin_q,       fin_n;
	logic        masked_q,    masked_n;
	logic [3:0]  hdr_cnt_q,   hdr_cnt_n;    // header bytes still to come
	logic [63:0] length_q,    length_n;
	logic [31:0] key_q,       key_n;        // key byte k in bits 8k+7..8k
	logic [63:0] remain_q,    remain_n;     // payload bytes still to come
	logic [1:0]  key_idx_q,   key_idx_n;    // payload index modulo four

	// Result register
	logic                  out_valid_q;
	wsd_pkg::result_item_t out_q;

	// Single-pass step logic
	logic                  advance;
	logic                  emit;
	logic                  do_after_len;
	logic                  do_start;
	logic [6:0]            len7;
	logic [1:0]            key_slot;
	logic [7:0]            key_byte;
	logic                  data_last;
	wsd_pkg::result_item_t res;

	// Move the held byte on whenever the result register can take a result
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign data.ready = !valid_s1 || advance;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	assign len7      = byte_s1[6:0];
	assign key_slot  = 2'(wsd_pkg::KEY_BYTES - hdr_cnt_q);
	assign key_byte  = masked_q ? key_q[{key_idx_q, 3'b000} +: 8] : 8'd0;
	assign data_last = (remain_q == 64'd1);

	always_comb begin
		phase_n      = phase_q;
		opcode_n     = opcode_q;
		fin_n        = fin_q;
		masked_n     = masked_q;
		hdr_cnt_n    = hdr_cnt_q;
		length_n     = length_q;
		key_n        = key_q;
		remain_n     = remain_q;
		key_idx_n    = key_idx_q;
		emit         = 1'b0;
		do_after_len = 1'b0;
		do_start     = 1'b0;
		res.payload_byte  = 8'd0;
		res.empty_frame   = 1'b0;
		res.last_of_frame = 1'b0;

		case (phase_q)
			PH_HDR1: begin
				masked_n = byte_s1[7];
				if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
					length_n  = 64'd0;
					hdr_cnt_n = (len7 == wsd_pkg::LEN_EXT16) ?
						wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
					phase_n   = PH_EXT;
				end else begin
					length_n     = {57'd0, len7};
					do_after_len = 1'b1;
				end
			end
			PH_EXT: begin
				// shift the big-endian length in a byte at a time
				length_n  = {length_q[55:0], byte_s1};
				hdr_cnt_n = hdr_cnt_q - 4'd1;
				do_after_len = (hdr_cnt_q == 4'd1);
			end
			PH_MASK: begin
				key_n[{key_slot, 3'b000} +: 8] = byte_s1;
				hdr_cnt_n = hdr_cnt_q - 4'd1;
				do_start  = (hdr_cnt_q == 4'd1);
			end
			PH_DATA: begin
				emit              = 1'b1;
				res.payload_byte  = byte_s1 ^ key_byte;
				res.last_of_frame = data_last;
				remain_n          = remain_q - 64'd1;
				key_idx_n         = key_idx_q + 2'd1;
				if (data_last) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
				opcode_n = byte_s1[3:0];
				fin_n    = byte_s1[7];
				phase_n  = PH_HDR1;
			end
		endcase

		// Length known: collect the mask key, or go straight to the payload
		if (do_after_len) begin
			if (masked_n) begin
				key_n     = 32'd0;
				hdr_cnt_n = wsd_pkg::KEY_BYTES;
				phase_n   = PH_MASK;
			end else begin
				do_start = 1'b1;
			end
		end

		// Header complete: a zero-length frame reports one empty item
		if (do_start) begin
			remain_n  = length_n;
			key_idx_n = 2'd0;
			if (length_n == 64'd0) begin
				emit              = 1'b1;
				res.payload_byte  = 8'd0;
				res.empty_frame   = 1'b1;
				res.last_of_frame = 1'b1;
				phase_n           = PH_HDR0;
			end else begin
				phase_n = PH_DATA;
			end
		end

		res.opcode       = opcode_n;
		res.fin_flag     = fin_n;
		res.was_masked   = masked_n;
		res.frame_length = length_n;
	end

	// Input register: hold the byte until the step logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1 <= data.payload.data_byte;
		end
	end

	// Frame state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			opcode_q    <= 4'd0;
			fin_q       <= 1'b0;
			masked_q    <= 1'b0;
			hdr_cnt_q   <= 4'd0;
			length_q    <= 64'd0;
			key_q       <= 32'd0;
			remain_q    <= 64'd0;
			key_idx_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q   <= phase_n;
				opcode_q  <= opcode_n;
				fin_q     <= fin_n;
				masked_q  <= masked_n;
				hdr_cnt_q <= hdr_cnt_n;
				length_q  <= length_n;
				key_q     <= key_n;
				remain_q  <= remain_n;
				key_idx_q <= key_idx_n;
			end
			// load a new result, or drop the one just taken
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.empty_frame |-> out_q.last_of_frame && out_q.payload_byte == 8'd0)
		else $error("empty-frame item not marked last or carries data");

	a_mask_phase_masked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MASK |-> masked_q && hdr_cnt_q != 4'd0 && hdr_cnt_q <= wsd_pkg::KEY_BYTES)
		else $error("mask key phase without mask flag or with bad byte count");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXT |-> hdr_cnt_q != 4'd0 && hdr_cnt_q <= wsd_pkg::EXT64_BYTES)
		else $error("extended length byte count out of range");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_DATA && data_last |=> phase_q == PH_HDR0 && out_valid_q
		&& out_q.last_of_frame)
		else $error("final payload byte did not restart the header parse");

	a_data_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> remain_q != 64'd0)
		else $error("payload phase with nothing left to receive");
`endif

endmodule
